// ----- rtl/cufp_pkg.sv -----
// shared types, codes and constants of the checksummed uart frame parser
// no dependencies; compiled first
package cufp_pkg;

    localparam int MAX_PARAMS_DEF = 8;
    // length byte, command byte and checksum byte
    localparam int FRAME_OVERHEAD = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd2;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_LEN,
        PH_PAYLOAD,
        PH_END
    } t_phase;

    typedef enum logic [2:0] {
        STAT_NONE     = 3'd0,
        STAT_FRAME    = 3'd1,
        STAT_CSUM     = 3'd2,
        STAT_FRAMING  = 3'd3,
        STAT_LENGTH   = 3'd4,
        STAT_TIMEOUT  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_PUSH
    } t_ctrl_state;

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [7:0]  end_marker;
        logic [15:0] timeout_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        start_marker:  8'd126,
        end_marker:    8'd239,
        timeout_limit: 16'd200
    };

    typedef struct packed {
        logic accept;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
        logic frame_params;
        logic emit_last;
    } t_dp_status;

endpackage

// ----- rtl/cufp_in_if.sv -----
// request channel into the frame parser: one received byte or one timer tick
// no dependencies
interface cufp_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  data_byte;
    logic [31:0] now_time;

    modport source (output valid, output op, output data_byte, output now_time, input ready);
    modport sink   (input valid, input op, input data_byte, input now_time, output ready);
endinterface

// ----- rtl/cufp_out_if.sv -----
// result channel out of the frame parser
// no dependencies
interface cufp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] command;
    logic [3:0] param_count;
    logic [2:0] param_index;
    logic [7:0] param_byte;
    logic [7:0] frame_checksum;
    logic       last;

    modport source (
        output valid, output status, output command, output param_count,
        output param_index, output param_byte, output frame_checksum, output last,
        input ready
    );
    modport sink (
        input valid, input status, input command, input param_count,
        input param_index, input param_byte, input frame_checksum, input last,
        output ready
    );
endinterface

// ----- rtl/cufp_ctrl.sv -----
// controller of the frame parser: takes requests and sequences the result burst
// depends on cufp_pkg
module cufp_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_out_ready,
    input  cufp_pkg::t_dp_status   i_status,
    output cufp_pkg::t_dp_cmd      o_cmd
);
    import cufp_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        out_free;

    assign out_free = !i_status.out_busy || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && out_free && i_status.frame_params) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (out_free) begin
                    n_state = i_status.emit_last ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.push   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = out_free;
                o_cmd.accept = i_in_valid && out_free;
            end
            ST_PUSH: begin
                o_cmd.push = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/cufp_datapath.sv -----
// datapath of the frame parser: parse state, payload memory and result register
// depends on cufp_pkg
module cufp_datapath #(
    parameter int MAX_PARAMS = cufp_pkg::MAX_PARAMS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cufp_pkg::t_cfg       i_cfg,
    input  cufp_pkg::t_dp_cmd    i_cmd,
    output cufp_pkg::t_dp_status o_status,
    input  logic                 i_op,
    input  logic [7:0]           i_data_byte,
    input  logic [31:0]          i_now_time,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [2:0]           o_res_status,
    output logic [7:0]           o_command,
    output logic [3:0]           o_param_count,
    output logic [2:0]           o_param_index,
    output logic [7:0]           o_param_byte,
    output logic [7:0]           o_frame_checksum,
    output logic                 o_last
);
    import cufp_pkg::*;

    localparam int STORE_DEPTH = MAX_PARAMS + 2;
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam logic [8:0] LEN_MIN = 9'(FRAME_OVERHEAD);
    localparam logic [8:0] LEN_MAX = 9'(MAX_PARAMS + FRAME_OVERHEAD);

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] command;
        logic [3:0] param_count;
        logic [2:0] param_index;
        logic [7:0] param_byte;
        logic [7:0] frame_checksum;
        logic       last;
    } t_result;

    t_phase      r_phase,       n_phase;
    logic [7:0]  r_frame_length, n_frame_length;
    logic [7:0]  r_pos,         n_pos;
    logic [7:0]  r_sum,         n_sum;
    logic [31:0] r_start_time,  n_start_time;
    logic [7:0]  r_cmd_byte,    n_cmd_byte;
    logic [7:0]  r_csum_byte,   n_csum_byte;
    logic [IW-1:0] r_emit_idx;
    logic [7:0]  r_mem [STORE_DEPTH];
    logic [7:0]  r_rd_data;
    logic        r_out_valid;
    t_result     r_res, n_res;

    logic        is_tick, is_start, timed_out, len_ok, csum_ok, end_ok;
    logic        sum_take, payload_done, mem_we, res_load, res_good;
    logic [31:0] elapsed;
    logic [7:0]  nparam, pos_next;
    logic [AW-1:0] rd_addr;
    t_status     res_code;

    assign is_tick      = (i_op == OP_TICK);
    assign is_start     = !is_tick && (i_data_byte == i_cfg.start_marker);
    assign elapsed      = i_now_time - r_start_time;
    assign timed_out    = (r_phase != PH_WAIT) && (i_cfg.timeout_limit != 16'd0)
                          && (elapsed >= {16'd0, i_cfg.timeout_limit});
    assign len_ok       = ({1'b0, i_data_byte} >= LEN_MIN) && ({1'b0, i_data_byte} <= LEN_MAX);
    assign nparam       = r_frame_length - 8'(FRAME_OVERHEAD);
    assign csum_ok      = (r_csum_byte == r_sum);
    assign end_ok       = (i_data_byte == i_cfg.end_marker);
    assign pos_next     = r_pos + 8'd1;
    assign sum_take     = ({1'b0, r_pos} + 9'd2) < {1'b0, r_frame_length};
    assign payload_done = pos_next >= (r_frame_length - 8'd1);
    assign rd_addr      = AW'(r_emit_idx) + AW'(1);

    assign o_status.out_busy     = r_out_valid;
    assign o_status.frame_params = !is_tick && !is_start && (r_phase == PH_END)
                                   && end_ok && csum_ok && (nparam != 8'd0);
    assign o_status.emit_last    = ((8'(r_emit_idx) + 8'd1) == nparam);

    // parse step for one accepted request
    always_comb begin
        n_phase        = r_phase;
        n_frame_length = r_frame_length;
        n_pos          = r_pos;
        n_sum          = r_sum;
        n_start_time   = r_start_time;
        n_cmd_byte     = r_cmd_byte;
        n_csum_byte    = r_csum_byte;
        mem_we         = 1'b0;
        res_load       = 1'b0;
        res_good       = 1'b0;
        res_code       = STAT_NONE;
        if (i_cmd.accept) begin
            if (is_tick) begin
                if (timed_out) begin
                    n_phase  = PH_WAIT;
                    res_load = 1'b1;
                    res_code = STAT_TIMEOUT;
                end
            end else if (is_start) begin
                n_phase      = PH_LEN;
                n_start_time = i_now_time;
                if (r_phase == PH_END) begin
                    res_load = 1'b1;
                    res_code = STAT_FRAMING;
                end
            end else begin
                unique case (r_phase)
                    PH_WAIT: begin
                        n_phase = PH_WAIT;
                    end
                    PH_LEN: begin
                        if (!len_ok) begin
                            n_phase  = PH_WAIT;
                            res_load = 1'b1;
                            res_code = STAT_LENGTH;
                        end else begin
                            n_frame_length = i_data_byte;
                            n_pos          = 8'd0;
                            n_sum          = i_data_byte;
                            n_phase        = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        mem_we = ({1'b0, r_pos} < 9'(STORE_DEPTH));
                        if (r_pos == 8'd0) begin
                            n_cmd_byte = i_data_byte;
                        end
                        // the last payload byte is the received checksum
                        n_csum_byte = i_data_byte;
                        if (sum_take) begin
                            n_sum = r_sum + i_data_byte;
                        end
                        n_pos = pos_next;
                        if (payload_done) begin
                            n_phase = PH_END;
                        end
                    end
                    PH_END: begin
                        n_phase = PH_WAIT;
                        if (!end_ok) begin
                            res_load = 1'b1;
                            res_code = STAT_FRAMING;
                        end else if (!csum_ok) begin
                            res_load = 1'b1;
                            res_code = STAT_CSUM;
                        end else if (nparam == 8'd0) begin
                            res_load = 1'b1;
                            res_good = 1'b1;
                            res_code = STAT_FRAME;
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_res = r_res;
        if (res_load) begin
            n_res.status         = res_code;
            n_res.command        = res_good ? r_cmd_byte : 8'd0;
            n_res.param_count    = 4'd0;
            n_res.param_index    = 3'd0;
            n_res.param_byte     = 8'd0;
            n_res.frame_checksum = res_good ? r_csum_byte : 8'd0;
            n_res.last           = 1'b1;
        end else if (i_cmd.push) begin
            n_res.status         = STAT_FRAME;
            n_res.command        = r_cmd_byte;
            n_res.param_count    = nparam[3:0];
            n_res.param_index    = 3'(8'(r_emit_idx));
            n_res.param_byte     = r_rd_data;
            n_res.frame_checksum = r_csum_byte;
            n_res.last           = o_status.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_WAIT;
            r_frame_length <= 8'd0;
            r_pos          <= 8'd0;
            r_sum          <= 8'd0;
            r_start_time   <= 32'd0;
            r_emit_idx     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_frame_length <= n_frame_length;
            r_pos          <= n_pos;
            r_sum          <= n_sum;
            r_start_time   <= n_start_time;
            if (i_cmd.accept) begin
                r_emit_idx <= '0;
            end else if (i_cmd.push && !o_status.emit_last) begin
                r_emit_idx <= r_emit_idx + IW'(1);
            end
            if (res_load || i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd_byte  <= n_cmd_byte;
        r_csum_byte <= n_csum_byte;
        r_res       <= n_res;
    end

    // payload store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_pos[AW-1:0]] <= i_data_byte;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_out_valid      = r_out_valid;
    assign o_res_status     = r_res.status;
    assign o_command        = r_res.command;
    assign o_param_count    = r_res.param_count;
    assign o_param_index    = r_res.param_index;
    assign o_param_byte     = r_res.param_byte;
    assign o_frame_checksum = r_res.frame_checksum;
    assign o_last           = r_res.last;

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD || r_phase == PH_END) |->
        ({1'b0, r_frame_length} >= LEN_MIN && {1'b0, r_frame_length} <= LEN_MAX))
        else $error("open frame holds a length outside the legal range");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_pos < (r_frame_length - 8'd1)))
        else $error("payload position ran past the checksum byte");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept || i_cmd.push) |-> (!r_out_valid || i_out_ready))
        else $error("result register loaded while holding an untaken result");

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (8'(r_emit_idx) < nparam))
        else $error("parameter index beyond the frame's parameter count");

endmodule

// ----- rtl/checksummed_uart_frame_parser_core.sv -----
// top level of the checksummed uart frame parser: config registers plus
// controller and datapath; depends on cufp_pkg, cufp_in_if, cufp_out_if,
// cufp_ctrl and cufp_datapath
//
// Parses start/length/command/params/checksum/end frames from a stream of
// requests, each one received byte or one timer tick with a millisecond
// timestamp. A byte or tick request is taken whenever the result register
// is empty or being drained; a request that finishes a good frame with P
// parameter bytes then holds off new requests while the burst of P results
// is read out of the payload memory, each result by a registered memory
// read and then a result-register load that waits while the sink stalls.
// Errors, timeouts and a good frame without parameters give one result,
// valid from the cycle after the request is taken. Configuration registers
// are written through the plain write port and should only change while no
// frame result is pending.
module checksummed_uart_frame_parser_core #(
    parameter int MAX_PARAMS = cufp_pkg::MAX_PARAMS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    cufp_in_if.sink                             i_in,
    cufp_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [cufp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cufp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import cufp_pkg::*;

    // config registers: start marker, end marker, timeout limit
    t_cfg       r_cfg;
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_MARKER: r_cfg.start_marker  <= i_cfg_wdata[7:0];
                CFG_END_MARKER:   r_cfg.end_marker    <= i_cfg_wdata[7:0];
                CFG_TIMEOUT:      r_cfg.timeout_limit <= i_cfg_wdata[15:0];
                // writes to unused indexes are dropped
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // controller: request handshake and result burst sequencing
    cufp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // datapath: parse state, checksum, payload memory, result register
    cufp_datapath #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .i_op             (i_in.op),
        .i_data_byte      (i_in.data_byte),
        .i_now_time       (i_in.now_time),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_res_status     (o_out.status),
        .o_command        (o_out.command),
        .o_param_count    (o_out.param_count),
        .o_param_index    (o_out.param_index),
        .o_param_byte     (o_out.param_byte),
        .o_frame_checksum (o_out.frame_checksum),
        .o_last           (o_out.last)
    );

endmodule

// ----- tb/tb_top.sv -----
// self-checking bench for checksummed_uart_frame_parser_core: byte and tick
// requests go in through a queued driver, a request-level frame predictor builds
// the expected results; depends on cufp_pkg, cufp_in_if, cufp_out_if and the rtl
module tb_top;
    import cufp_pkg::*;

    localparam int STORE_DEPTH   = MAX_PARAMS_DEF + 2;
    localparam int MIN_LENGTH    = FRAME_OVERHEAD;
    localparam int MAX_LENGTH    = MAX_PARAMS_DEF + FRAME_OVERHEAD;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 27;

    // the index port is two bits wide, the last index has no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        logic        op;
        logic [7:0]  data_byte;
        logic [31:0] now_time;
    } t_parser_request;

    typedef struct packed {
        t_status    status;
        logic [7:0] command;
        logic [3:0] param_count;
        logic [2:0] param_index;
        logic [7:0] param_byte;
        logic [7:0] frame_checksum;
        logic       last;
    } t_parse_result;

    typedef logic [7:0] t_byte_q[$];

    // how a generated frame is damaged on its way in
    typedef enum {
        FLAW_NONE,
        FLAW_CSUM,
        FLAW_END,
        FLAW_RESTART,
        FLAW_TRUNC
    } t_frame_flaw;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // the driver and monitor own these; the interfaces follow them from time zero
    logic            req_valid   = 1'b0;
    t_parser_request req_payload = '0;
    logic            res_ready   = 1'b0;

    // idle chances in percent, changed by the stimulus between phases
    int send_idle_pct = 25;
    int recv_idle_pct = 82;

    int fail_count  = 0;
    int cycle_count = 0;

    cufp_in_if  req_if ();
    cufp_out_if res_if ();

    assign req_if.valid     = req_valid;
    assign req_if.op        = req_payload.op;
    assign req_if.data_byte = req_payload.data_byte;
    assign req_if.now_time  = req_payload.now_time;
    assign res_if.ready     = res_ready;

    checksummed_uart_frame_parser_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (req_if),
        .o_out       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // frame predictor: its own copy of the registers and the parse state
    // ------------------------------------------------------------------
    logic [7:0]  marker_open = 8'd126;
    logic [7:0]  marker_close = 8'd239;
    logic [15:0] limit_ms = 16'd200;

    t_phase      rx_phase = PH_WAIT;
    logic [7:0]  rx_len = 8'd0;
    logic [7:0]  rx_pos = 8'd0;
    logic [7:0]  rx_sum = 8'd0;
    logic [31:0] rx_start_ms = 32'd0;
    logic [7:0]  rx_store [STORE_DEPTH];

    t_parser_request pending_requests[$];
    t_parse_result   expected_results[$];

    task automatic drop_frame();
        rx_phase    = PH_WAIT;
        rx_len      = 8'd0;
        rx_pos      = 8'd0;
        rx_sum      = 8'd0;
        rx_start_ms = 32'd0;
    endtask

    task automatic queue_result(input t_status status, input logic [7:0] command,
                                input logic [3:0] count, input logic [2:0] index,
                                input logic [7:0] pbyte, input logic [7:0] csum,
                                input logic last);
        t_parse_result r;
        r.status         = status;
        r.command        = command;
        r.param_count    = count;
        r.param_index    = index;
        r.param_byte     = pbyte;
        r.frame_checksum = csum;
        r.last           = last;
        expected_results.push_back(r);
    endtask

    // advance the parse state by one accepted request and queue what it emits
    task automatic parse_request(input t_parser_request req);
        logic       was_closing;
        int         nparam;
        logic [7:0] cmd;
        logic [7:0] csum;
        if (req.op == OP_TICK) begin
            // elapsed time wraps modulo 2^32
            if (rx_phase != PH_WAIT && limit_ms != 16'd0 &&
                (req.now_time - rx_start_ms) >= {16'd0, limit_ms}) begin
                drop_frame();
                queue_result(STAT_TIMEOUT, 8'd0, 4'd0, 3'd0, 8'd0, 8'd0, 1'b1);
            end
        end else if (req.data_byte == marker_open) begin
            // start marker restarts from any phase, only an awaited end complains
            was_closing = (rx_phase == PH_END);
            drop_frame();
            rx_phase    = PH_LEN;
            rx_start_ms = req.now_time;
            if (was_closing)
                queue_result(STAT_FRAMING, 8'd0, 4'd0, 3'd0, 8'd0, 8'd0, 1'b1);
        end else begin
            case (rx_phase)
                PH_LEN: begin
                    if (req.data_byte < MIN_LENGTH || req.data_byte > MAX_LENGTH) begin
                        drop_frame();
                        queue_result(STAT_LENGTH, 8'd0, 4'd0, 3'd0, 8'd0, 8'd0, 1'b1);
                    end else begin
                        rx_len   = req.data_byte;
                        rx_pos   = 8'd0;
                        rx_sum   = req.data_byte;
                        rx_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (rx_pos < STORE_DEPTH)
                        rx_store[rx_pos] = req.data_byte;
                    // checksum byte itself is not summed
                    if (rx_pos + 2 < rx_len)
                        rx_sum = rx_sum + req.data_byte;
                    rx_pos = rx_pos + 8'd1;
                    if (rx_pos >= rx_len - 1)
                        rx_phase = PH_END;
                end
                PH_END: begin
                    if (req.data_byte != marker_close) begin
                        drop_frame();
                        queue_result(STAT_FRAMING, 8'd0, 4'd0, 3'd0, 8'd0, 8'd0, 1'b1);
                    end else begin
                        nparam = rx_len - FRAME_OVERHEAD;
                        cmd    = rx_store[0];
                        csum   = rx_store[(rx_len - 2) % STORE_DEPTH];
                        if (csum != rx_sum) begin
                            drop_frame();
                            queue_result(STAT_CSUM, 8'd0, 4'd0, 3'd0, 8'd0, 8'd0, 1'b1);
                        end else begin
                            drop_frame();
                            if (nparam == 0) begin
                                queue_result(STAT_FRAME, cmd, 4'd0, 3'd0, 8'd0, csum, 1'b1);
                            end else begin
                                for (int i = 0; i < nparam; i++)
                                    queue_result(STAT_FRAME, cmd, 4'(nparam), 3'(i),
                                                 rx_store[(1 + i) % STORE_DEPTH], csum,
                                                 (i + 1 == nparam));
                            end
                        end
                    end
                end
                default: begin
                    // bytes outside a frame are dropped
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // request driver: offers the head of the pending queue, holds it
    // steady until taken, idles at random between requests
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : request_driver
        logic taken;
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else begin
            taken = req_valid && req_if.ready;
            if (taken)
                parse_request(pending_requests.pop_front());
            if (!req_valid || taken) begin
                if (pending_requests.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    req_valid   <= 1'b1;
                    req_payload <= pending_requests[0];
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: every accepted result against the oldest expectation
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_parse_result want;
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (res_if.valid && res_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected, status %0d", res_if.status);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", want.status, res_if.status);
                    compare_field("command", want.command, res_if.command);
                    compare_field("param_count", want.param_count, res_if.param_count);
                    compare_field("param_index", want.param_index, res_if.param_index);
                    compare_field("param_byte", want.param_byte, res_if.param_byte);
                    compare_field("frame_checksum", want.frame_checksum,
                                  res_if.frame_checksum);
                    compare_field("last", want.last, res_if.last);
                end
            end
            res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers: build request sequences into the pending queue
    // ------------------------------------------------------------------
    logic [31:0] ms_clock = 32'hFFFF_FFF0;  // starts near the wrap point
    logic [31:0] frame_open_ms = 32'd0;
    int          counted_requests = 0;

    task automatic add_request(input logic op, input logic [7:0] b, input logic [31:0] t);
        t_parser_request r;
        r.op        = op;
        r.data_byte = b;
        r.now_time  = t;
        pending_requests.push_back(r);
        counted_requests++;
    endtask

    // bytes arrive zero to three ms apart
    task automatic add_byte(input logic [7:0] b);
        ms_clock = ms_clock + $urandom_range(0, 3);
        add_request(OP_BYTE, b, ms_clock);
    endtask

    // payload content that does not restart the frame
    function automatic logic [7:0] content_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom);
        end while (b == marker_open);
        return b;
    endfunction

    // command byte followed by a random number of parameter bytes
    function automatic t_byte_q random_body();
        t_byte_q body;
        int      nparam;
        nparam = $urandom_range(0, MAX_PARAMS_DEF);
        for (int i = 0; i <= nparam; i++)
            body.push_back(content_byte());
        return body;
    endfunction

    // start, length, body, checksum, end marker; the flaw damages one piece
    task automatic add_frame(input t_byte_q body, input t_frame_flaw flaw);
        t_byte_q    seq;
        logic [7:0] sum;
        logic [7:0] closer;
        int         cut;
        sum = 8'(body.size() + 2);
        seq.push_back(sum);
        foreach (body[i]) begin
            seq.push_back(body[i]);
            sum = sum + body[i];
        end
        if (flaw == FLAW_CSUM)
            sum = sum ^ 8'($urandom_range(1, 255));
        seq.push_back(sum);
        if (flaw == FLAW_END) begin
            do begin
                closer = 8'($urandom);
            end while (closer == marker_close || closer == marker_open);
        end else if (flaw == FLAW_RESTART) begin
            closer = marker_open;
        end else begin
            closer = marker_close;
        end
        seq.push_back(closer);
        // a truncated frame stops after the start marker and before its checksum byte
        cut = (flaw == FLAW_TRUNC) ? $urandom_range(0, seq.size() - 2) : seq.size();
        add_byte(marker_open);
        frame_open_ms = ms_clock;
        for (int i = 0; i < cut; i++)
            add_byte(seq[i]);
    endtask

    // mostly well-formed frames with random content, the rest broken or noise;
    // noise requests do not count toward the target
    task automatic queue_traffic(input int target);
        int          added;
        int          mark;
        int          pick;
        int          jump;
        logic [7:0]  bad_len;
        logic [31:0] slack;
        added = 0;
        while (added < target) begin
            mark = counted_requests;
            pick = $urandom_range(0, 99);
            jump = $urandom_range(0, 99);
            if (jump < 4)
                ms_clock = $urandom;
            else if (jump < 6)
                ms_clock = 32'hFFFF_FFF0;
            if (pick < 55) begin
                add_frame(random_body(), FLAW_NONE);
            end else if (pick < 65) begin
                add_frame(random_body(), FLAW_CSUM);
            end else if (pick < 72) begin
                add_frame(random_body(), FLAW_END);
            end else if (pick < 77) begin
                add_frame(random_body(), FLAW_RESTART);
            end else if (pick < 83) begin
                do begin
                    bad_len = $urandom_range(0, 1) ? 8'($urandom_range(0, MIN_LENGTH - 1))
                                                   : 8'($urandom_range(MAX_LENGTH + 1, 255));
                end while (bad_len == marker_open);
                add_byte(marker_open);
                add_byte(bad_len);
            end else if (pick < 92) begin
                // open frame, then a tick just short of, at or past the deadline
                add_frame(random_body(), FLAW_TRUNC);
                case ($urandom_range(0, 3))
                    0:       slack = 32'hFFFF_FFFF;
                    1:       slack = 32'd0;
                    2:       slack = 32'd1;
                    default: slack = $urandom_range(2, 5000);
                endcase
                ms_clock = frame_open_ms + {16'd0, limit_ms} + slack;
                add_request(OP_TICK, 8'($urandom), ms_clock);
            end else if (pick < 96) begin
                add_frame(random_body(), FLAW_TRUNC);
            end else if ($urandom_range(0, 1)) begin
                add_byte(content_byte());
            end else begin
                ms_clock = ms_clock + $urandom_range(0, 100000);
                add_request(OP_TICK, 8'($urandom), ms_clock);
            end
            if (pick < 96)
                added += counted_requests - mark;
        end
    endtask

    // sender holds off until every request is taken and every result is in,
    // then the block is left to settle with no traffic
    task automatic wait_until_quiet();
        do begin
            @(posedge i_clk);
        end while (pending_requests.size() != 0 || req_valid ||
                   expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write per clock; the predictor copy changes with it
    task automatic program_register(input logic [CFG_IDX_W-1:0] index,
                                    input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        case (index)
            CFG_START_MARKER: marker_open  = value[7:0];
            CFG_END_MARKER:   marker_close = value[7:0];
            CFG_TIMEOUT:      limit_ms     = value;
            default: begin
                // unused index, write is dropped
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_byte_q body;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part on reset registers: tick with nothing open, shortest
        // and longest good frames across the timestamp wrap, a start marker
        // where the end is due, then a zero length byte
        add_request(OP_TICK, 8'hFF, ms_clock);
        body = {8'hFF};
        add_frame(body, FLAW_NONE);
        body = {8'h00, 8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA, 8'h7F, 8'hFE, 8'h00};
        add_frame(body, FLAW_NONE);
        body = {8'h00};
        add_frame(body, FLAW_RESTART);
        add_byte(8'h00);
        wait_until_quiet();

        for (int phase = 0; phase < 6; phase++) begin
            // sender light / receiver heavy, then swapped, then no idling
            if (phase < 2) begin
                send_idle_pct = 25;
                recv_idle_pct = 82;
            end else if (phase < 4) begin
                send_idle_pct = 82;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case (phase)
                0: begin
                    // upper data bits must be masked off the byte registers
                    program_register(CFG_START_MARKER, 16'hA500);
                    program_register(CFG_END_MARKER, 16'h00FF);
                    program_register(CFG_TIMEOUT, 16'd1);
                    program_register(CFG_UNUSED_INDEX, 16'hFFFF);
                end
                1: begin
                    program_register(CFG_START_MARKER, 16'h00FF);
                    program_register(CFG_END_MARKER, 16'hFF00);
                    program_register(CFG_TIMEOUT, 16'hFFFF);
                end
                2: begin
                    // timeout off
                    program_register(CFG_START_MARKER, 16'($urandom));
                    program_register(CFG_END_MARKER, 16'($urandom));
                    program_register(CFG_TIMEOUT, 16'd0);
                end
                3: begin
                    program_register(CFG_START_MARKER, 16'h007E);
                    program_register(CFG_END_MARKER, 16'h00EF);
                    program_register(CFG_TIMEOUT, 16'($urandom_range(1, 300)));
                end
                4: begin
                    program_register(CFG_START_MARKER, 16'($urandom));
                    program_register(CFG_END_MARKER, 16'($urandom));
                    program_register(CFG_TIMEOUT, 16'($urandom));
                end
                default: begin
                    program_register(CFG_START_MARKER, 16'h0055);
                    program_register(CFG_END_MARKER, 16'h00AA);
                    program_register(CFG_TIMEOUT, 16'd200);
                end
            endcase
            @(posedge i_clk);
            cfg_we <= 1'b0;

            // two halves with a full drain between them
            queue_traffic(PHASE_ITEMS);
            wait_until_quiet();
            queue_traffic(PHASE_ITEMS);
            wait_until_quiet();
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
